// ===== rtl/uvsph_pkg.sv =====
// Shared types, constants and tables of the UV sphere mesh generator.
package uvsph_pkg;

    localparam int LINE_W      = 9;
    localparam int DVD_W       = 27;
    localparam int ANG_W       = 19;
    localparam int XY_W        = 34;
    localparam int Z_W         = 28;
    localparam int CORDIC_ITER = 16;
    localparam int IDX_W       = 18;

    localparam int MAX_LINES_DEF  = 256;
    localparam int INDEX_BITS_DEF = 16;

    localparam logic [17:0] ANG_PITCH_SPAN = 18'd205783;
    localparam logic [18:0] ANG_YAW_SPAN   = 19'd411566;
    localparam logic signed [20:0] ANG_PI      = 21'sd205887;
    localparam logic signed [20:0] ANG_HALF_PI = 21'sd102944;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic [LINE_W-1:0] LINES_RESET = 9'd10;

    typedef enum logic [2:0] {
        PH_TOP_POLE = 3'd0,
        PH_RINGS    = 3'd1,
        PH_BOT_POLE = 3'd2,
        PH_TOP_CAP  = 3'd3,
        PH_MIDDLE   = 3'd4,
        PH_BOT_CAP  = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_TRI    = 2'd1,
        KIND_NONE   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DIV_P,
        SQ_DIV_Y,
        SQ_COR_P,
        SQ_COR_Y,
        SQ_MUL_X,
        SQ_MUL_Y,
        SQ_FIN
    } seq_t;

    localparam logic CFG_LAT = 1'b0;
    localparam logic CFG_LON = 1'b1;

    // arctangent of 2^-k in Q.24
    function automatic logic [23:0] atan_q24(input logic [3:0] k);
        logic [23:0] v;
        case (k)
            4'd0:    v = 24'd13176795;
            4'd1:    v = 24'd7778716;
            4'd2:    v = 24'd4110060;
            4'd3:    v = 24'd2086331;
            4'd4:    v = 24'd1047214;
            4'd5:    v = 24'd524117;
            4'd6:    v = 24'd262123;
            4'd7:    v = 24'd131069;
            4'd8:    v = 24'd65536;
            4'd9:    v = 24'd32768;
            4'd10:   v = 24'd16384;
            4'd11:   v = 24'd8192;
            4'd12:   v = 24'd4096;
            4'd13:   v = 24'd2048;
            4'd14:   v = 24'd1024;
            4'd15:   v = 24'd512;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/uvsph_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module uvsph_div
    import uvsph_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DVD_W-1:0]      dividend,
    input  logic [LINE_W-1:0]     divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [LINE_W:0]   rem_reg, rem_next;
    logic [LINE_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [LINE_W:0]   rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg[LINE_W-1:0], dvd_reg[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            rem_next = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== rtl/uvsph_cordic.sv =====
// Iterative rotation CORDIC giving sine and cosine in Q1.14.
module uvsph_cordic
    import uvsph_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ANG_W-1:0]        angle,
    output logic                    done,
    output logic signed [15:0]      sin_q14,
    output logic signed [15:0]      cos_q14
);

    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [3:0]             k_reg, k_next;
    logic                   flip_reg, flip_next;
    logic                   busy_reg, busy_next;
    logic                   rnd_reg, rnd_next;
    logic                   done_reg, done_next;
    logic signed [15:0]     sin_reg, sin_next, cos_reg, cos_next;

    logic signed [20:0]     a0, a1, a2;
    logic                   f1, f2;
    logic signed [28:0]     z_wide;
    logic signed [XY_W-1:0] dx, dy, xr, yr;
    logic signed [Z_W-1:0]  at;

    function automatic logic signed [15:0] clamp14(input logic signed [XY_W-1:0] v);
        logic signed [15:0] r;
        if (v > XY_W'(ONE_Q14))
            r = ONE_Q14;
        else if (v < -XY_W'(ONE_Q14))
            r = -ONE_Q14;
        else
            r = v[15:0];
        return r;
    endfunction

    always_comb
    begin
        // fold the angle into [-pi/2, pi/2]
        a0 = signed'({2'b00, angle});
        f1 = a0 > ANG_HALF_PI;
        a1 = f1 ? (a0 - ANG_PI) : a0;
        f2 = a1 > ANG_HALF_PI;
        a2 = f2 ? (a1 - ANG_PI) : a1;
        z_wide = {a2, 8'd0};

        dx = y_reg >>> k_reg;
        dy = x_reg >>> k_reg;
        at = Z_W'(atan_q24(k_reg));
        xr = (x_reg + XY_W'(32768)) >>> 16;
        yr = (y_reg + XY_W'(32768)) >>> 16;
        if (flip_reg)
        begin
            xr = -xr;
            yr = -yr;
        end

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        k_next    = k_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        rnd_next  = 1'b0;
        done_next = 1'b0;
        sin_next  = sin_reg;
        cos_next  = cos_reg;
        if (start)
        begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = z_wide[Z_W-1:0];
            k_next    = '0;
            flip_next = f1 ^ f2;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            k_next = k_reg + 1'b1;
            if (k_reg == 4'(CORDIC_ITER - 1))
            begin
                busy_next = 1'b0;
                rnd_next  = 1'b1;
            end
        end
        else if (rnd_reg)
        begin
            cos_next  = clamp14(xr);
            sin_next  = clamp14(yr);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
    end

    assign done    = done_reg;
    assign sin_q14 = sin_reg;
    assign cos_q14 = cos_reg;

endmodule

// ===== rtl/uv_sphere_mesh_generator.sv =====
// Top level of the UV sphere mesh generator: sequencer, mesh walk and output register.
// Poles, triangles and "nothing left" answers appear in the cycle after acceptance.
// A ring vertex takes two divisions on the shared divider, two shared CORDIC passes and
// the multiply and rounding states. One transaction is in flight at a time; outside
// ring vertices the throughput is one transaction per cycle while out_stall is low.
// Reset (rst_n, asynchronous, active low): mesh finished, both line counts back to 10.
module uv_sphere_mesh_generator
    import uvsph_pkg::*;
#(
    parameter int MAX_LINES  = MAX_LINES_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic signed [15:0]  pos_x,
    output logic signed [15:0]  pos_y,
    output logic signed [15:0]  pos_z,
    output logic [15:0]         index_a,
    output logic [15:0]         index_b,
    output logic [15:0]         index_c,
    output logic                last,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [LINE_W-1:0]   cfg_data
);

    localparam logic [15:0] IDX_MASK = (INDEX_BITS >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << INDEX_BITS) - 32'd1);
    localparam logic [LINE_W-1:0] MAX_L = LINE_W'(MAX_LINES);

    // configuration and latched mesh size
    logic [LINE_W-1:0] lat_lines_reg, lat_lines_next, lon_lines_reg, lon_lines_next;
    logic [LINE_W-1:0] lat_used_reg, lat_used_next, lon_used_reg, lon_used_next;

    // mesh walk
    phase_t            phase_reg, phase_next;
    logic [LINE_W-1:0] ring_reg, ring_next, col_reg, col_next;
    logic              half_reg, half_next;
    logic [15:0]       row_base_reg, row_base_next;

    // ring vertex sequencer
    seq_t              seq_reg, seq_next;
    logic [DVD_W-1:0]  yaw_dvd_reg, yaw_dvd_next;
    logic [LINE_W-1:0] yaw_dsr_reg, yaw_dsr_next;
    logic [ANG_W-1:0]  p_ang_reg, p_ang_next;
    logic signed [15:0] sp_reg, sp_next, cp_reg, cp_next, cy_reg, cy_next, sy_reg, sy_next;
    logic signed [31:0] prod_reg, prod_next;
    logic signed [15:0] px_reg, px_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg, kind_next;
    logic signed [15:0] px_out_reg, px_out_next, py_out_reg, py_out_next;
    logic signed [15:0] pz_out_reg, pz_out_next;
    logic [15:0]       ia_reg, ia_next, ib_reg, ib_next, ic_reg, ic_next;
    logic              last_reg, last_next;

    // shared units
    logic              div_start, div_done;
    logic [DVD_W-1:0]  div_dvd, div_quo;
    logic [LINE_W-1:0] div_dsr;
    logic              cor_start, cor_done;
    logic [ANG_W-1:0]  cor_ang;
    logic signed [15:0] cor_sin, cor_cos;

    // accept-cycle working values
    logic              accept, out_free;
    phase_t            e_phase;
    logic [LINE_W-1:0] e_lat, e_lon, e_ring, e_col;
    logic              e_half;
    logic [15:0]       e_rb;
    logic [LINE_W-1:0] rings;
    logic [IDX_W-1:0]  nv, top, n_w, col_w, rb_w, ta, tb, tc, td;
    logic [LINE_W:0]   col_inc, ring_inc;
    logic [DVD_W-1:0]  pitch_dvd;

    function automatic logic [LINE_W-1:0] clamp_lines(input logic [LINE_W-1:0] v);
        logic [LINE_W-1:0] r;
        if (v < LINE_W'(3))
            r = LINE_W'(3);
        else if (v > MAX_L)
            r = MAX_L;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [15:0] rnd_q14(input logic signed [31:0] p);
        logic signed [31:0] t;
        t = (p + 32'sd8192) >>> 14;
        return t[15:0];
    endfunction

    function automatic logic [15:0] idx(input logic [IDX_W-1:0] v);
        return v[15:0] & IDX_MASK;
    endfunction

    uvsph_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    uvsph_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_ang),
        .done    (cor_done),
        .sin_q14 (cor_sin),
        .cos_q14 (cor_cos)
    );

    // take a new transaction only when idle and the output register can take a result
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (seq_reg != SQ_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        // a restart reloads the mesh size and rewinds the walk before this element
        e_lat   = restart ? clamp_lines(lat_lines_reg) : lat_used_reg;
        e_lon   = restart ? clamp_lines(lon_lines_reg) : lon_used_reg;
        e_phase = restart ? PH_TOP_POLE : phase_reg;
        e_ring  = restart ? '0 : ring_reg;
        e_col   = restart ? '0 : col_reg;
        e_half  = restart ? 1'b0 : half_reg;
        e_rb    = restart ? '0 : row_base_reg;

        rings    = e_lat - LINE_W'(2);
        nv       = IDX_W'(rings * e_lon) + IDX_W'(2);
        top      = nv - IDX_W'(1);
        n_w      = IDX_W'(e_lon);
        col_w    = IDX_W'(e_col);
        rb_w     = IDX_W'(e_rb);
        col_inc  = {1'b0, e_col} + 1'b1;
        ring_inc = {1'b0, e_ring} + 1'b1;
        pitch_dvd = DVD_W'(ring_inc * ANG_PITCH_SPAN);

        // middle band corners, wrapping at the seam
        ta = rb_w + col_w + IDX_W'(1);
        tc = rb_w + n_w + col_w + IDX_W'(1);
        tb = (col_inc >= {1'b0, e_lon}) ? rb_w + IDX_W'(1) : rb_w + col_w + IDX_W'(2);
        td = (col_inc >= {1'b0, e_lon}) ? rb_w + n_w + IDX_W'(1)
                                        : rb_w + n_w + col_w + IDX_W'(2);

        lat_lines_next = lat_lines_reg;
        lon_lines_next = lon_lines_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_LAT)
                lat_lines_next = cfg_data;
            else
                lon_lines_next = cfg_data;
        end

        lat_used_next = lat_used_reg;
        lon_used_next = lon_used_reg;
        phase_next    = phase_reg;
        ring_next     = ring_reg;
        col_next      = col_reg;
        half_next     = half_reg;
        row_base_next = row_base_reg;

        seq_next     = seq_reg;
        yaw_dvd_next = yaw_dvd_reg;
        yaw_dsr_next = yaw_dsr_reg;
        p_ang_next   = p_ang_reg;
        sp_next      = sp_reg;
        cp_next      = cp_reg;
        sy_next      = sy_reg;
        cy_next      = cy_reg;
        prod_next    = prod_reg;
        px_next      = px_reg;

        div_start = 1'b0;
        div_dvd   = pitch_dvd;
        div_dsr   = e_lat - LINE_W'(1);
        cor_start = 1'b0;
        cor_ang   = p_ang_reg;

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        px_out_next    = px_out_reg;
        py_out_next    = py_out_reg;
        pz_out_next    = pz_out_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        ic_next        = ic_reg;
        last_next      = last_reg;

        if (accept)
        begin
            lat_used_next = e_lat;
            lon_used_next = e_lon;
            phase_next    = e_phase;
            ring_next     = e_ring;
            col_next      = e_col;
            half_next     = e_half;
            row_base_next = e_rb;

            // default result shape: triangle, positions zero
            kind_next   = KIND_TRI;
            px_out_next = '0;
            py_out_next = '0;
            pz_out_next = '0;
            ia_next     = '0;
            ib_next     = '0;
            ic_next     = '0;
            last_next   = 1'b0;
            out_valid_next = 1'b1;

            case (e_phase)
                PH_TOP_POLE:
                begin
                    kind_next   = KIND_VERTEX;
                    pz_out_next = ONE_Q14;
                    phase_next  = PH_RINGS;
                    ring_next   = '0;
                    col_next    = '0;
                end
                PH_RINGS:
                begin
                    // hold the result back until the sequencer finishes the vertex
                    out_valid_next = 1'b0;
                    div_start    = 1'b1;
                    yaw_dvd_next = DVD_W'(e_col * ANG_YAW_SPAN);
                    yaw_dsr_next = e_lon;
                    seq_next     = SQ_DIV_P;
                    if (col_inc >= {1'b0, e_lon})
                    begin
                        col_next  = '0;
                        ring_next = ring_inc[LINE_W-1:0];
                        if (ring_inc >= {1'b0, rings})
                            phase_next = PH_BOT_POLE;
                    end
                    else
                    begin
                        col_next = col_inc[LINE_W-1:0];
                    end
                end
                PH_BOT_POLE:
                begin
                    kind_next   = KIND_VERTEX;
                    pz_out_next = -ONE_Q14;
                    phase_next  = PH_TOP_CAP;
                    col_next    = '0;
                end
                PH_TOP_CAP:
                begin
                    if (col_inc < {1'b0, e_lon})
                    begin
                        ib_next = idx(col_w + IDX_W'(1));
                        ic_next = idx(col_w + IDX_W'(2));
                        col_next = col_inc[LINE_W-1:0];
                    end
                    else
                    begin
                        ib_next = idx(n_w);
                        ic_next = idx(IDX_W'(1));
                        col_next      = '0;
                        ring_next     = '0;
                        half_next     = 1'b0;
                        row_base_next = '0;
                        phase_next    = (rings > LINE_W'(1)) ? PH_MIDDLE : PH_BOT_CAP;
                    end
                end
                PH_MIDDLE:
                begin
                    if (!e_half)
                    begin
                        ia_next   = idx(ta);
                        ib_next   = idx(tb);
                        ic_next   = idx(tc);
                        half_next = 1'b1;
                    end
                    else
                    begin
                        ia_next   = idx(tc);
                        ib_next   = idx(tb);
                        ic_next   = idx(td);
                        half_next = 1'b0;
                        if (col_inc >= {1'b0, e_lon})
                        begin
                            col_next      = '0;
                            ring_next     = ring_inc[LINE_W-1:0];
                            row_base_next = e_rb + 16'(e_lon);
                            if ((ring_inc + 1'b1) >= {1'b0, rings})
                                phase_next = PH_BOT_CAP;
                        end
                        else
                        begin
                            col_next = col_inc[LINE_W-1:0];
                        end
                    end
                end
                PH_BOT_CAP:
                begin
                    ia_next = idx(top);
                    if (col_inc < {1'b0, e_lon})
                    begin
                        ib_next  = idx(top - col_w - IDX_W'(1));
                        ic_next  = idx(top - col_w - IDX_W'(2));
                        col_next = col_inc[LINE_W-1:0];
                    end
                    else
                    begin
                        ib_next    = idx(top - n_w);
                        ic_next    = idx(nv - IDX_W'(2));
                        last_next  = 1'b1;
                        col_next   = '0;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    kind_next  = KIND_NONE;
                    phase_next = PH_DONE;
                end
            endcase
        end

        case (seq_reg)
            SQ_IDLE:
            begin
            end
            SQ_DIV_P:
            begin
                if (div_done)
                begin
                    p_ang_next = div_quo[ANG_W-1:0];
                    div_start  = 1'b1;
                    div_dvd    = yaw_dvd_reg;
                    div_dsr    = yaw_dsr_reg;
                    seq_next   = SQ_DIV_Y;
                end
            end
            SQ_DIV_Y:
            begin
                if (div_done)
                begin
                    // keep the yaw quotient in the divider; start on pitch
                    cor_start = 1'b1;
                    cor_ang   = p_ang_reg;
                    seq_next  = SQ_COR_P;
                end
            end
            SQ_COR_P:
            begin
                if (cor_done)
                begin
                    sp_next   = cor_sin;
                    cp_next   = cor_cos;
                    cor_start = 1'b1;
                    cor_ang   = div_quo[ANG_W-1:0];
                    seq_next  = SQ_COR_Y;
                end
            end
            SQ_COR_Y:
            begin
                if (cor_done)
                begin
                    sy_next  = cor_sin;
                    cy_next  = cor_cos;
                    seq_next = SQ_MUL_X;
                end
            end
            SQ_MUL_X:
            begin
                prod_next = sp_reg * sy_reg;
                seq_next  = SQ_MUL_Y;
            end
            SQ_MUL_Y:
            begin
                px_next   = rnd_q14(prod_reg);
                prod_next = (-sp_reg) * cy_reg;
                seq_next  = SQ_FIN;
            end
            SQ_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_VERTEX;
                    px_out_next    = px_reg;
                    py_out_next    = rnd_q14(prod_reg);
                    pz_out_next    = cp_reg;
                    ia_next        = '0;
                    ib_next        = '0;
                    ic_next        = '0;
                    last_next      = 1'b0;
                    seq_next       = SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_lines_reg <= LINES_RESET;
            lon_lines_reg <= LINES_RESET;
            lat_used_reg  <= LINES_RESET;
            lon_used_reg  <= LINES_RESET;
            phase_reg     <= PH_DONE;
            ring_reg      <= '0;
            col_reg       <= '0;
            half_reg      <= 1'b0;
            row_base_reg  <= '0;
            seq_reg       <= SQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lat_lines_reg <= lat_lines_next;
            lon_lines_reg <= lon_lines_next;
            lat_used_reg  <= lat_used_next;
            lon_used_reg  <= lon_used_next;
            phase_reg     <= phase_next;
            ring_reg      <= ring_next;
            col_reg       <= col_next;
            half_reg      <= half_next;
            row_base_reg  <= row_base_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        yaw_dvd_reg <= yaw_dvd_next;
        yaw_dsr_reg <= yaw_dsr_next;
        p_ang_reg   <= p_ang_next;
        sp_reg      <= sp_next;
        cp_reg      <= cp_next;
        sy_reg      <= sy_next;
        cy_reg      <= cy_next;
        prod_reg    <= prod_next;
        px_reg      <= px_next;
        kind_reg    <= kind_next;
        px_out_reg  <= px_out_next;
        py_out_reg  <= py_out_next;
        pz_out_reg  <= pz_out_next;
        ia_reg      <= ia_next;
        ib_reg      <= ib_next;
        ic_reg      <= ic_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign pos_x     = px_out_reg;
    assign pos_y     = py_out_reg;
    assign pos_z     = pz_out_reg;
    assign index_a   = ia_reg;
    assign index_b   = ib_reg;
    assign index_c   = ic_reg;
    assign last      = last_reg;

    // a finished mesh answers "nothing left" on a plain request
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !restart && phase_reg == PH_DONE |=> out_valid_reg && kind_reg == KIND_NONE)
        else $error("finished mesh did not answer nothing left");

    // every accepted transaction either shows a result or keeps the sequencer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg || seq_reg != SQ_IDLE)
        else $error("accepted transaction produced no result");

    // the shared units only report completion while the sequencer waits on them
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_done || cor_done) |-> seq_reg != SQ_IDLE)
        else $error("shared unit finished with no vertex in progress");

    // a restart always begins with the top pole
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> out_valid_reg && kind_reg == KIND_VERTEX
                              && pz_out_reg == ONE_Q14)
        else $error("restart did not emit the top pole");

endmodule
